>>> hw/rtl/ps2mq_pkg.sv
package ps2mq_pkg;

    localparam int FrameBits  = 11;
    localparam int LinkStates = 19;

    localparam logic [7:0]  ByteAck      = 8'hFA;
    localparam logic [7:0]  ByteSelfTest = 8'hAA;
    localparam logic [15:0] PosCenter    = 16'h8000;
    localparam logic [15:0] PosHighEdge  = 16'h8010;
    localparam logic [15:0] PosLowEdge   = 16'h7FF0;
    localparam logic [15:0] PosStepMask  = 16'hFFF0;

    typedef enum logic [1:0] {
        OP_BIT  = 2'd0,
        OP_TICK = 2'd1,
        OP_CMD  = 2'd2,
        OP_NONE = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        RP_IDLE   = 3'd0,
        RP_RESET  = 3'd1,
        RP_READ   = 3'd2,
        RP_STREAM = 3'd3,
        RP_REMOTE = 3'd4,
        RP_RATE   = 3'd5,
        RP_RATE2  = 3'd6,
        RP_WRAP   = 3'd7
    } t_reply;

    // bit position of each state is its external link_state number
    typedef enum logic [LinkStates-1:0] {
        ST_IDLE       = 19'h00001,
        ST_RESET      = 19'h00002,
        ST_RESET_ACK  = 19'h00004,
        ST_SELFTEST   = 19'h00008,
        ST_READ       = 19'h00010,
        ST_READ0      = 19'h00020,
        ST_READ1      = 19'h00040,
        ST_READ2      = 19'h00080,
        ST_STREAM_CMD = 19'h00100,
        ST_REMOTE_CMD = 19'h00200,
        ST_RATE       = 19'h00400,
        ST_RATE_ACK   = 19'h00800,
        ST_RATE2      = 19'h01000,
        ST_REMOTE     = 19'h02000,
        ST_STREAM0    = 19'h04000,
        ST_STREAM1    = 19'h08000,
        ST_STREAM2    = 19'h10000,
        ST_WRAP_CMD   = 19'h20000,
        ST_WRAP       = 19'h40000
    } t_link_state;

    typedef struct packed {
        logic       done;
        logic [7:0] data;
    } t_rx_byte;

    typedef struct packed {
        logic       valid;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
    } t_pkt_evt;

    function automatic logic [1:0] gray2(input logic [1:0] v);
        gray2 = {v[1], v[1] ^ v[0]};
    endfunction

    function automatic logic [4:0] link_code(input t_link_state s);
        logic [4:0] c;
        c = '0;
        for (int i = 0; i < LinkStates; i++) begin
            if (s[i]) begin
                c = c | 5'(i);
            end
        end
        link_code = c;
    endfunction

    function automatic t_link_state reply_state(input logic [2:0] r);
        t_link_state s;
        case (t_reply'(r))
            RP_IDLE:   s = ST_IDLE;
            RP_RESET:  s = ST_RESET;
            RP_READ:   s = ST_READ;
            RP_STREAM: s = ST_STREAM_CMD;
            RP_REMOTE: s = ST_REMOTE_CMD;
            RP_RATE:   s = ST_RATE;
            RP_RATE2:  s = ST_RATE2;
            RP_WRAP:   s = ST_WRAP_CMD;
            default:   s = ST_IDLE;
        endcase
        reply_state = s;
    endfunction

endpackage

>>> hw/rtl/ps2_mouse_to_quadrature_core.sv
// An input transfer is held in the input register and its result is then
// loaded into the output register, from which it can transfer.
// Throughput: one item per cycle unless the result register stalls; the
// state update for an item is a single pass of logic between the input register and the result register.
// A full input register is held whenever the result register is full and stalled.
// Reset (synchronous, active low) empties both registers, returns the link to
// idle, clears frame and packet state and centers all positions at 0x8000.
module ps2_mouse_to_quadrature_core
    import ps2mq_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_opcode,
    input  logic       i_data_bit,
    input  logic [2:0] i_expected_reply,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [1:0] o_quad_x,
    output logic [1:0] o_quad_y,
    output logic       o_left_button_n,
    output logic       o_right_button_n,
    output logic       o_mouse_ready,
    output logic [4:0] o_link_state,
    output logic       o_byte_done,
    output logic [7:0] o_last_byte
);

    logic       r_in_valid;
    logic [1:0] r_opcode;
    logic       r_data_bit;
    logic [2:0] r_reply;

    logic       r_out_valid;
    logic [1:0] r_quad_x, r_quad_y;
    logic       r_left_n, r_right_n, r_ready, r_done;
    logic [4:0] r_link;
    logic [7:0] r_last;

    logic       advance, en;
    t_rx_byte   rx;
    t_pkt_evt   pkt;
    logic [7:0] last_byte;
    logic [4:0] link;
    logic       ready;
    logic [1:0] buttons;
    logic [1:0] quad_x, quad_y;

    assign advance    = !r_out_valid || !i_out_stall;
    assign en         = r_in_valid && advance;
    assign o_in_stall = r_in_valid && !advance;

    ps2mq_rx u_rx (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_opcode    (r_opcode),
        .i_data_bit  (r_data_bit),
        .o_rx        (rx),
        .o_last_byte (last_byte)
    );

    ps2mq_link u_link (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_en             (en),
        .i_opcode         (r_opcode),
        .i_expected_reply (r_reply),
        .i_rx             (rx),
        .o_pkt            (pkt),
        .o_link_state     (link),
        .o_ready          (ready),
        .o_buttons        (buttons)
    );

    ps2mq_pos u_pos (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_opcode (r_opcode),
        .i_pkt    (pkt),
        .o_quad_x (quad_x),
        .o_quad_y (quad_y)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_opcode   <= i_opcode;
            r_data_bit <= i_data_bit;
            r_reply    <= i_expected_reply;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    // load the result of the item that updates state in this cycle
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_quad_x  <= quad_x;
            r_quad_y  <= quad_y;
            r_left_n  <= !buttons[0];
            r_right_n <= !buttons[1];
            r_ready   <= ready;
            r_link    <= link;
            r_done    <= rx.done;
            r_last    <= last_byte;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_quad_x         = r_quad_x;
    assign o_quad_y         = r_quad_y;
    assign o_left_button_n  = r_left_n;
    assign o_right_button_n = r_right_n;
    assign o_mouse_ready    = r_ready;
    assign o_link_state     = r_link;
    assign o_byte_done      = r_done;
    assign o_last_byte      = r_last;

endmodule

>>> hw/rtl/ps2mq_rx.sv
module ps2mq_rx
    import ps2mq_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic [1:0]     i_opcode,
    input  logic           i_data_bit,
    output t_rx_byte       o_rx,
    output logic [7:0]     o_last_byte
);

    logic [FrameBits-1:0] r_shift, n_shift;
    logic [3:0]           r_count, n_count;
    logic [7:0]           r_held, n_held;
    logic [3:0]           count_inc;
    logic [FrameBits-1:0] shift_in;
    logic                 rx_done;

    assign count_inc = r_count + 4'd1;
    assign shift_in  = {i_data_bit, r_shift[FrameBits-1:1]};

    always_comb begin
        n_shift = r_shift;
        n_count = r_count;
        n_held  = r_held;
        rx_done = 1'b0;
        if (i_en) begin
            case (t_opcode'(i_opcode))
                OP_BIT: begin
                    n_shift = shift_in;
                    n_count = count_inc;
                    if (count_inc >= 4'(FrameBits)) begin
                        n_count = '0;
                        n_held  = shift_in[8:1];
                        rx_done = 1'b1;
                    end
                end
                OP_CMD: begin
                    n_shift = '0;
                    n_count = '0;
                end
                default: ;
            endcase
        end
    end

    assign o_rx        = {rx_done, n_held};
    assign o_last_byte = n_held;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift <= '0;
            r_count <= '0;
            r_held  <= '0;
        end else begin
            r_shift <= n_shift;
            r_count <= n_count;
            r_held  <= n_held;
        end
    end

endmodule

>>> hw/rtl/ps2mq_link.sv
module ps2mq_link
    import ps2mq_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic [1:0]     i_opcode,
    input  logic [2:0]     i_expected_reply,
    input  t_rx_byte       i_rx,
    output t_pkt_evt       o_pkt,
    output logic [4:0]     o_link_state,
    output logic           o_ready,
    output logic [1:0]     o_buttons
);

    t_link_state r_state, n_state;
    logic [7:0]  r_pkt0, n_pkt0;
    logic [7:0]  r_pkt1, n_pkt1;
    logic [7:0]  r_pkt2, n_pkt2;
    logic        r_ready, n_ready;
    logic        is_ack;
    logic [7:0]  b;
    logic        pkt_valid;

    assign b      = i_rx.data;
    assign is_ack = (b == ByteAck);

    always_comb begin
        n_state   = r_state;
        n_pkt0    = r_pkt0;
        n_pkt1    = r_pkt1;
        n_pkt2    = r_pkt2;
        n_ready   = r_ready;
        pkt_valid = 1'b0;
        if (i_en) begin
            case (t_opcode'(i_opcode))
                OP_CMD: n_state = reply_state(i_expected_reply);
                OP_BIT: begin
                    if (i_rx.done) begin
                        case (r_state)
                            ST_STREAM0: begin
                                n_pkt0  = b;
                                n_state = ST_STREAM1;
                            end
                            ST_STREAM1: begin
                                n_pkt1  = b;
                                n_state = ST_STREAM2;
                            end
                            ST_STREAM2: begin
                                n_pkt2    = b;
                                n_state   = ST_STREAM0;
                                pkt_valid = 1'b1;
                            end
                            ST_RESET:      n_state = is_ack ? ST_RESET_ACK : ST_IDLE;
                            ST_RESET_ACK: begin
                                if (b == ByteSelfTest) begin
                                    n_state = ST_SELFTEST;
                                end
                            end
                            ST_SELFTEST: begin
                                if (b == 8'h00) begin
                                    n_ready = 1'b1;
                                end
                                n_state = ST_IDLE;
                            end
                            ST_READ:       n_state = is_ack ? ST_READ0 : ST_IDLE;
                            ST_READ0: begin
                                n_pkt0  = b;
                                n_state = ST_READ1;
                            end
                            ST_READ1: begin
                                n_pkt1  = b;
                                n_state = ST_READ2;
                            end
                            ST_READ2: begin
                                n_pkt2  = b;
                                n_state = ST_IDLE;
                            end
                            ST_STREAM_CMD: n_state = is_ack ? ST_STREAM0 : ST_IDLE;
                            ST_REMOTE_CMD: n_state = is_ack ? ST_REMOTE : ST_IDLE;
                            ST_RATE: begin
                                if (is_ack) begin
                                    n_state = ST_RATE_ACK;
                                end
                            end
                            ST_RATE2: begin
                                if (is_ack) begin
                                    n_state = ST_IDLE;
                                end
                            end
                            ST_WRAP_CMD: begin
                                if (is_ack) begin
                                    n_state = ST_WRAP;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                default: ;
            endcase
        end
    end

    // packet bytes as seen before this byte, plus the new third byte
    assign o_pkt = {pkt_valid, r_pkt0, r_pkt1, b};

    assign o_link_state = link_code(n_state);
    assign o_ready      = n_ready;
    assign o_buttons    = n_pkt0[1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pkt0  <= '0;
            r_pkt1  <= '0;
            r_pkt2  <= '0;
            r_ready <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pkt0  <= n_pkt0;
            r_pkt1  <= n_pkt1;
            r_pkt2  <= n_pkt2;
            r_ready <= n_ready;
        end
    end

endmodule

>>> hw/rtl/ps2mq_pos.sv
module ps2mq_pos
    import ps2mq_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic [1:0]     i_opcode,
    input  t_pkt_evt       i_pkt,
    output logic [1:0]     o_quad_x,
    output logic [1:0]     o_quad_y
);

    logic [15:0] r_out_x, n_out_x;
    logic [15:0] r_out_y, n_out_y;
    logic [15:0] r_tgt_x, n_tgt_x;
    logic [15:0] r_tgt_y, n_tgt_y;
    logic [15:0] dx_hi, dx_lo, dy_hi, dy_lo;
    logic [15:0] rc_out_x, rc_out_y, rc_tgt_x, rc_tgt_y;
    logic [15:0] mv_x, mv_y;

    assign dx_hi = (r_out_x - PosCenter) & PosStepMask;
    assign dx_lo = (PosCenter - r_out_x) & PosStepMask;
    assign dy_hi = (r_out_y - PosCenter) & PosStepMask;
    assign dy_lo = (PosCenter - r_out_y) & PosStepMask;

    assign mv_x = {{8{i_pkt.b0[4]}}, i_pkt.b1};
    assign mv_y = {{8{i_pkt.b0[5]}}, i_pkt.b2};

    // recenter both positions in steps of 16 before applying the packet movement
    always_comb begin
        rc_out_x = r_out_x;
        rc_tgt_x = r_tgt_x;
        rc_out_y = r_out_y;
        rc_tgt_y = r_tgt_y;
        if (r_out_x >= PosHighEdge) begin
            rc_out_x = r_out_x - dx_hi;
            rc_tgt_x = r_tgt_x - dx_hi;
        end else if (r_out_x < PosLowEdge) begin
            rc_out_x = r_out_x + dx_lo;
            rc_tgt_x = r_tgt_x + dx_lo;
        end
        if (r_out_y >= PosHighEdge) begin
            rc_out_y = r_out_y - dy_hi;
            rc_tgt_y = r_tgt_y - dy_hi;
        end else if (r_out_y <= PosLowEdge) begin
            rc_out_y = r_out_y + dy_lo;
            rc_tgt_y = r_tgt_y + dy_lo;
        end
    end

    always_comb begin
        n_out_x = r_out_x;
        n_out_y = r_out_y;
        n_tgt_x = r_tgt_x;
        n_tgt_y = r_tgt_y;
        if (i_en) begin
            case (t_opcode'(i_opcode))
                OP_TICK: begin
                    if (r_out_x < r_tgt_x) begin
                        n_out_x = r_out_x + 16'd1;
                    end else if (r_out_x > r_tgt_x) begin
                        n_out_x = r_out_x - 16'd1;
                    end
                    if (r_out_y < r_tgt_y) begin
                        n_out_y = r_out_y + 16'd1;
                    end else if (r_out_y > r_tgt_y) begin
                        n_out_y = r_out_y - 16'd1;
                    end
                end
                OP_BIT: begin
                    if (i_pkt.valid) begin
                        n_out_x = rc_out_x;
                        n_out_y = rc_out_y;
                        n_tgt_x = rc_tgt_x - mv_x;
                        n_tgt_y = rc_tgt_y + mv_y;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_quad_x = gray2(n_out_x[1:0]);
    assign o_quad_y = gray2(n_out_y[1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_x <= PosCenter;
            r_out_y <= PosCenter;
            r_tgt_x <= PosCenter;
            r_tgt_y <= PosCenter;
        end else begin
            r_out_x <= n_out_x;
            r_out_y <= n_out_y;
            r_tgt_x <= n_tgt_x;
            r_tgt_y <= n_tgt_y;
        end
    end

endmodule
